// ===== hw/rtl/pml_pkg.sv =====
// Shared types, register map and field helpers for the periodic minimum-image link block.
package pml_pkg;

  localparam int REG_W     = 63;
  localparam int FIELD_W   = 21;
  localparam int POS_W     = 32;
  localparam int DSQ_W     = 63;
  localparam int REG_COUNT = 6;
  localparam int ADDR_W    = 6;

  // Register indexes, byte address is 8 times the index.
  localparam logic [2:0] REG_BOX_A = 3'd0;
  localparam logic [2:0] REG_BOX_B = 3'd1;
  localparam logic [2:0] REG_BOX_C = 3'd2;
  localparam logic [2:0] REG_INV_1 = 3'd3;
  localparam logic [2:0] REG_INV_2 = 3'd4;
  localparam logic [2:0] REG_INV_3 = 3'd5;

  // Reset values: unit box vectors (Q9.12) and identity inverse columns (Q3.18).
  localparam logic [REG_W-1:0] RST_BOX_A = 63'd1 << 12;
  localparam logic [REG_W-1:0] RST_BOX_B = 63'd1 << 33;
  localparam logic [REG_W-1:0] RST_BOX_C = 63'd1 << 54;
  localparam logic [REG_W-1:0] RST_INV_1 = 63'd1 << 18;
  localparam logic [REG_W-1:0] RST_INV_2 = 63'd1 << 39;
  localparam logic [REG_W-1:0] RST_INV_3 = 63'd1 << 60;

  localparam logic [DSQ_W-1:0] DSQ_MAX = {DSQ_W{1'b1}};

  typedef struct packed {
    logic signed [POS_W-1:0] p1_x;
    logic signed [POS_W-1:0] p1_y;
    logic signed [POS_W-1:0] p1_z;
    logic signed [POS_W-1:0] p2_x;
    logic signed [POS_W-1:0] p2_y;
    logic signed [POS_W-1:0] p2_z;
  } pos_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] link_x;
    logic signed [POS_W-1:0] link_y;
    logic signed [POS_W-1:0] link_z;
    logic [DSQ_W-1:0]        dist_sq;
  } link_item_t;

  // Extracts packed component k (0 = x, 1 = y, 2 = z) of a register.
  function automatic logic signed [FIELD_W-1:0] reg_field(input logic [REG_W-1:0] r,
                                                          input int k);
    return $signed(r[FIELD_W*k +: FIELD_W]);
  endfunction

endpackage

// ===== hw/rtl/periodic_minimum_image_link.sv =====
// Minimum-image link and squared length of two positions in a triclinic periodic box.
// Throughput: one position pair per cycle while the output is not stalled; the
// seven-stage pipeline with a valid bit per stage sets that figure, and a stalled
// output only backs up the stages behind it.
// Reset (rst, synchronous, active high) empties the pipeline and loads the unit box
// and identity inverse into the configuration registers.
module periodic_minimum_image_link (
  input  logic                         clk,
  input  logic                         rst,
  // Position pair channel.
  input  logic                         pos_valid,
  output logic                         pos_ready,
  input  pml_pkg::pos_item_t           pos,
  // Result channel.
  output logic                         link_valid,
  input  logic                         link_ready,
  output pml_pkg::link_item_t          link,
  // APB-style configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pml_pkg::ADDR_W-1:0]   paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);
  import pml_pkg::*;

  localparam int NSTG = 7;

  // ---------------------------------------------------------------------------
  // Configuration registers. Bit 63 of a write is dropped and writes beyond the
  // last register are ignored. The pipeline reads these directly; the user must
  // change them only while no transfer is in flight, which is not enforced here.
  // ---------------------------------------------------------------------------
  logic [REG_W-1:0] cfg [REG_COUNT];
  logic [2:0]       reg_idx;

  assign reg_idx = paddr[5:3];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[REG_BOX_A] <= RST_BOX_A;
      cfg[REG_BOX_B] <= RST_BOX_B;
      cfg[REG_BOX_C] <= RST_BOX_C;
      cfg[REG_INV_1] <= RST_INV_1;
      cfg[REG_INV_2] <= RST_INV_2;
      cfg[REG_INV_3] <= RST_INV_3;
    end else if (psel && penable && pwrite && (reg_idx < 3'(REG_COUNT))) begin
      cfg[reg_idx] <= pwdata[REG_W-1:0];
    end
  end

  always_comb begin
    if (reg_idx < 3'(REG_COUNT)) begin
      prdata = {1'b0, cfg[reg_idx]};
    end else begin
      prdata = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. A stage takes new data when it is empty or when its
  // content moves on in the same cycle, so bubbles close up behind a stalled
  // output and nothing is dropped or repeated.
  // ---------------------------------------------------------------------------
  logic [NSTG:1] vld;
  logic [NSTG:1] rdy;

  always_comb begin
    rdy[NSTG] = !vld[NSTG] || link_ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign pos_ready  = rdy[1];
  assign link_valid = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= pos_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: exact 33-bit difference d = p2 - p1.
  // ---------------------------------------------------------------------------
  logic signed [POS_W:0] d_s1 [3];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      d_s1[0] <= 33'(pos.p2_x) - 33'(pos.p1_x);
      d_s1[1] <= 33'(pos.p2_y) - 33'(pos.p1_y);
      d_s1[2] <= 33'(pos.p2_z) - 33'(pos.p1_z);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the nine inverse-matrix products, each 21 by 33 bits with 34
  // fraction bits. Row i, column j is inv_col_j component i times d_j.
  // ---------------------------------------------------------------------------
  logic signed [53:0] prod_f [3][3];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_f[i][j] <= reg_field(cfg[3'(REG_INV_1) + 3'(j)], i) * d_s1[j];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: fractional coordinates f and the reduction. The nearest integer
  // is removed by keeping the 34 fraction bits and, when they exceed one half
  // (or equal it for a negative f, so ties go toward zero), subtracting one.
  // Subtracting one from the 34-bit fraction is just setting the sign bit.
  // ---------------------------------------------------------------------------
  logic signed [55:0] f_sum  [3];
  logic signed [34:0] g_next [3];
  logic signed [34:0] g_s3   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_sum[i]  = 56'(prod_f[i][0]) + 56'(prod_f[i][1]) + 56'(prod_f[i][2]);
      g_next[i] = {((f_sum[i][33:0] > 34'h2_0000_0000) ||
                    ((f_sum[i][33:0] == 34'h2_0000_0000) && f_sum[i][55])),
                   f_sum[i][33:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++) begin
        g_s3[i] <= g_next[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: the nine box-vector products with 46 fraction bits. Row i,
  // column j is box vector j component i times g_j.
  // ---------------------------------------------------------------------------
  logic signed [55:0] prod_l [3][3];

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_l[i][j] <= reg_field(cfg[3'(REG_BOX_A) + 3'(j)], i) * g_s3[j];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: link components rounded to Q16.16, to nearest with ties upward,
  // and their magnitudes for the length.
  // ---------------------------------------------------------------------------
  logic signed [58:0]      l_rnd  [3];
  logic signed [POS_W-1:0] q_next [3];
  logic signed [POS_W-1:0] q_s5   [3];
  logic [POS_W-1:0]        mag_s5 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      l_rnd[i]  = 59'(prod_l[i][0]) + 59'(prod_l[i][1]) + 59'(prod_l[i][2])
                  + 59'sd536870912;
      q_next[i] = POS_W'(l_rnd[i] >>> 30);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int i = 0; i < 3; i++) begin
        q_s5[i]   <= q_next[i];
        mag_s5[i] <= q_next[i][POS_W-1] ? (-q_next[i]) : q_next[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: squares of the magnitudes. Stage 7: their saturating sum, held
  // in the output register together with the link.
  // ---------------------------------------------------------------------------
  logic [63:0]             sq_s6   [3];
  logic signed [POS_W-1:0] link_s6 [3];
  logic [65:0]             sq_sum;
  link_item_t              out_item;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int i = 0; i < 3; i++) begin
        sq_s6[i]   <= 64'(mag_s5[i]) * 64'(mag_s5[i]);
        link_s6[i] <= q_s5[i];
      end
    end
  end

  assign sq_sum = 66'(sq_s6[0]) + 66'(sq_s6[1]) + 66'(sq_s6[2]);

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      out_item.link_x  <= link_s6[0];
      out_item.link_y  <= link_s6[1];
      out_item.link_z  <= link_s6[2];
      out_item.dist_sq <= (sq_sum > 66'(DSQ_MAX)) ? DSQ_MAX : sq_sum[DSQ_W-1:0];
    end
  end

  assign link = out_item;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // An empty first stage always takes a transfer.
  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !vld[1] |-> pos_ready)
    else $error("first stage empty but input not ready");

  // A pair in the first stage reaches the second stage in the next cycle when the second stage is ready.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (vld[1] && rdy[2]) |=> vld[2])
    else $error("stage one content lost");

  // A waiting third stage keeps its valid bit and its x and z components while the fourth stage is not ready.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[3] && !rdy[4]) |=> (vld[3] && $stable(g_s3[0]) && $stable(g_s3[2])))
    else $error("stalled stage three changed");

  // The reduced x fractional component taken into the third stage is at most one half.
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> (($past(g_next[0]) <= 35'sh2_0000_0000) || !$past(rdy[3])))
    else $error("reduced component above one half");

  // A zero link has a zero squared length.
  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    (link_valid && (link.link_x == 0) && (link.link_y == 0) && (link.link_z == 0))
      |-> (link.dist_sq == 0))
    else $error("zero link with nonzero length");

endmodule

// ===== verif/periodic_minimum_image_link_tb.sv =====
// Self-checking testbench for the periodic minimum-image link block.
`timescale 1ns / 1ps

module periodic_minimum_image_link_tb;
  import pml_pkg::*;

  // Register indexes that lie past the register map; writes there must change nothing.
  localparam logic [2:0] UNMAPPED_IDX_LO = 3'd6;
  localparam logic [2:0] UNMAPPED_IDX_HI = 3'd7;

  // Fixed-point constants of the fractional reduction (34 fraction bits) and of the
  // final rounding from 46 to 16 fraction bits.
  localparam logic [33:0] HALF_TURN  = 34'h2_0000_0000;
  localparam longint      ONE_TURN   = longint'(1) << 34;
  localparam longint      ROUND_BIAS = longint'(1) << 29;

  localparam int PIPE_LATENCY = 7;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_COUNT  = 9;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       pos_valid = 1'b0;
  logic       pos_ready;
  pos_item_t  pos = '0;
  logic       link_valid;
  logic       link_ready = 1'b0;
  link_item_t link;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [63:0]       pwdata = '0;
  logic [63:0]       prdata;
  logic              pready;

  // Mirror of the six box and inverse registers, as the block should hold them.
  logic [REG_W-1:0] box_and_inverse [REG_COUNT];

  pos_item_t  pending_pairs [$];
  link_item_t expected_links [$];
  link_item_t next_link;

  logic idling_on = 1'b1;
  int   send_gap = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  int   results_seen = 0;
  int   mismatch_count = 0;
  int   cycle_count = 0;

  periodic_minimum_image_link u_dut (
    .clk        (clk),
    .rst        (rst),
    .pos_valid  (pos_valid),
    .pos_ready  (pos_ready),
    .pos        (pos),
    .link_valid (link_valid),
    .link_ready (link_ready),
    .link       (link),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Signed 21-bit component k of a packed register, widened to 64 bits.
  function automatic longint axis_comp(input logic [REG_W-1:0] r, input int k);
    return longint'($signed(r[FIELD_W*k +: FIELD_W]));
  endfunction

  function automatic logic [REG_W-1:0] pack3(input logic [20:0] x, input logic [20:0] y,
                                             input logic [20:0] z);
    return {z, y, x};
  endfunction

  // Expected link for one position pair under the mirrored register contents.
  // The difference is exact at 33 bits, the fractional coordinates carry 34
  // fraction bits, and the map back carries 46 before rounding to Q16.16.
  function automatic link_item_t min_image_link(input pos_item_t pair);
    longint             span [3];
    longint             wrapped [3];
    longint             rounded [3];
    longint             frac;
    longint             acc;
    longint unsigned    mag;
    longint unsigned    dsq_sum;
    logic [33:0]        frac_lo;
    link_item_t         res;
    int                 i;
    int                 j;
    span[0] = longint'($signed(pair.p2_x)) - longint'($signed(pair.p1_x));
    span[1] = longint'($signed(pair.p2_y)) - longint'($signed(pair.p1_y));
    span[2] = longint'($signed(pair.p2_z)) - longint'($signed(pair.p1_z));
    for (i = 0; i < 3; i++) begin
      frac = 0;
      for (j = 0; j < 3; j++) begin
        frac += axis_comp(box_and_inverse[REG_INV_1 + j], i) * span[j];
      end
      // Drop the nearest integer; an exact half rounds toward zero, so the
      // remainder keeps the sign of the fractional coordinate.
      frac_lo = frac[33:0];
      wrapped[i] = longint'({30'b0, frac_lo});
      if (frac_lo > HALF_TURN || (frac_lo == HALF_TURN && frac < 0)) begin
        wrapped[i] -= ONE_TURN;
      end
    end
    dsq_sum = 0;
    for (i = 0; i < 3; i++) begin
      acc = 0;
      for (j = 0; j < 3; j++) begin
        acc += axis_comp(box_and_inverse[REG_BOX_A + j], i) * wrapped[j];
      end
      // Round to nearest with ties toward plus infinity; >>> is a floor here.
      rounded[i] = (acc + ROUND_BIAS) >>> 30;
      mag = (rounded[i] < 0) ? longint'(-rounded[i]) : longint'(rounded[i]);
      mag = mag & 64'hFFFF_FFFF;
      dsq_sum += mag * mag;
    end
    if (dsq_sum > 64'(DSQ_MAX)) begin
      dsq_sum = 64'(DSQ_MAX);
    end
    res.link_x  = rounded[0][31:0];
    res.link_y  = rounded[1][31:0];
    res.link_z  = rounded[2][31:0];
    res.dist_sq = dsq_sum[DSQ_W-1:0];
    return res;
  endfunction

  function automatic logic [REG_W-1:0] random_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[REG_W-1:0];
  endfunction

  // A coordinate on the half-unit grid within about +-128 units.
  function automatic logic [31:0] half_multiple();
    return 32'($urandom_range(0, 511)) * 32'h8000 - 32'h0080_0000;
  endfunction

  // Random pairs: fully random coordinates, near neighbors as they occur in a
  // real system, and coordinates on the half-unit grid where ties are common.
  function automatic pos_item_t random_pair();
    pos_item_t p;
    case ($urandom_range(0, 4))
      0, 1: begin
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end
      2, 3: begin
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        p.p2_x = p.p1_x + 32'($urandom_range(0, 1 << 23)) - 32'(1 << 22);
        p.p2_y = p.p1_y + 32'($urandom_range(0, 1 << 23)) - 32'(1 << 22);
        p.p2_z = p.p1_z + 32'($urandom_range(0, 1 << 23)) - 32'(1 << 22);
      end
      default: begin
        p = {half_multiple(), half_multiple(), half_multiple(),
             half_multiple(), half_multiple(), half_multiple()};
      end
    endcase
    return p;
  endfunction

  function automatic pos_item_t pair_of(input logic [31:0] ax, input logic [31:0] ay,
                                        input logic [31:0] az, input logic [31:0] bx,
                                        input logic [31:0] by, input logic [31:0] bz);
    return {ax, ay, az, bx, by, bz};
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at result %0d: %s", results_seen, msg);
    mismatch_count++;
  endtask

  // One register write: a setup phase, then an access phase. The register takes
  // the value at the edge that ends the access phase. Bit 63 is random, since
  // the block must ignore it.
  task automatic apb_write(input logic [2:0] idx, input logic [REG_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= {1'($urandom_range(0, 1)), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx < 3'(REG_COUNT)) begin
      box_and_inverse[idx] = value;
    end
  endtask

  task automatic load_box(input logic [REG_W-1:0] a, input logic [REG_W-1:0] b,
                          input logic [REG_W-1:0] c, input logic [REG_W-1:0] i1,
                          input logic [REG_W-1:0] i2, input logic [REG_W-1:0] i3);
    apb_write(REG_BOX_A, a);
    apb_write(REG_BOX_B, b);
    apb_write(REG_BOX_C, c);
    apb_write(REG_INV_1, i1);
    apb_write(REG_INV_2, i2);
    apb_write(REG_INV_3, i3);
  endtask

  // Sender. At each edge it first records the expectation for a pair whose
  // transfer completes at that edge, then decides what to offer next. Valid is
  // assigned once per edge, so a back-to-back stream never glitches low.
  always @(posedge clk) begin
    if (rst) begin
      pos_valid <= 1'b0;
    end else begin
      if (pos_valid && pos_ready) begin
        expected_links.push_back(min_image_link(pos));
      end
      if (!pos_valid || pos_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          pos_valid <= 1'b0;
        end else if (pending_pairs.size() != 0) begin
          pos       <= pending_pairs.pop_front();
          pos_valid <= 1'b1;
          if (idling_on && $urandom_range(0, 4) == 0) begin
            send_gap = $urandom_range(1, 13);
          end
        end else begin
          pos_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Every result transfer is checked against the oldest expectation.
  // Twice in the run the receiver holds off for a long stretch while the sender
  // keeps offering pairs, so the pipeline fills and has to push back.
  always @(posedge clk) begin
    if (rst) begin
      link_ready <= 1'b0;
    end else begin
      if (link_valid && link_ready) begin
        results_seen++;
        if (expected_links.size() == 0) begin
          flag_mismatch("result transfer with no pair outstanding");
        end else begin
          next_link = expected_links.pop_front();
          if (link.link_x !== next_link.link_x) begin
            flag_mismatch($sformatf("link_x got %h want %h", link.link_x, next_link.link_x));
          end
          if (link.link_y !== next_link.link_y) begin
            flag_mismatch($sformatf("link_y got %h want %h", link.link_y, next_link.link_y));
          end
          if (link.link_z !== next_link.link_z) begin
            flag_mismatch($sformatf("link_z got %h want %h", link.link_z, next_link.link_z));
          end
          if (link.dist_sq !== next_link.dist_sq) begin
            flag_mismatch($sformatf("dist_sq got %h want %h",
                                    link.dist_sq, next_link.dist_sq));
          end
        end
        if (results_seen == 400 || results_seen == 1100) begin
          hold_left = 300;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        link_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        link_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        link_ready <= 1'b0;
      end else begin
        link_ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_links.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus. Each phase after the first loads a register setting while the block is idle, then
  // streams pairs and waits until every expected result has been taken.
  initial begin
    int phase;
    int item_total;
    box_and_inverse[REG_BOX_A] = RST_BOX_A;
    box_and_inverse[REG_BOX_B] = RST_BOX_B;
    box_and_inverse[REG_BOX_C] = RST_BOX_C;
    box_and_inverse[REG_INV_1] = RST_INV_1;
    box_and_inverse[REG_INV_2] = RST_INV_2;
    box_and_inverse[REG_INV_3] = RST_INV_3;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      item_total = 230;
      case (phase)
        // The first phase runs on the reset contents: unit box, identity inverse.
        0: ;
        // Random and mutually inconsistent matrices; writes past the map are ignored.
        1, 7: begin
          load_box(random_word(), random_word(), random_word(),
                   random_word(), random_word(), random_word());
          apb_write(UNMAPPED_IDX_LO, random_word());
          apb_write(UNMAPPED_IDX_HI, random_word());
        end
        // Every field at -1.
        2: load_box({REG_W{1'b1}}, {REG_W{1'b1}}, {REG_W{1'b1}},
                    {REG_W{1'b1}}, {REG_W{1'b1}}, {REG_W{1'b1}});
        // Every field at its largest positive value.
        3: load_box(pack3(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF),
                    pack3(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF),
                    pack3(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF),
                    pack3(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF),
                    pack3(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF),
                    pack3(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF));
        // Every field at its most negative value.
        4: load_box(pack3(21'h100000, 21'h100000, 21'h100000),
                    pack3(21'h100000, 21'h100000, 21'h100000),
                    pack3(21'h100000, 21'h100000, 21'h100000),
                    pack3(21'h100000, 21'h100000, 21'h100000),
                    pack3(21'h100000, 21'h100000, 21'h100000),
                    pack3(21'h100000, 21'h100000, 21'h100000));
        // A physical orthorhombic box of 10 x 12 x 15 with its inverse.
        5: load_box(pack3(21'd40960, 21'd0, 21'd0),
                    pack3(21'd0, 21'd49152, 21'd0),
                    pack3(21'd0, 21'd0, 21'd61440),
                    pack3(21'd26214, 21'd0, 21'd0),
                    pack3(21'd0, 21'd21845, 21'd0),
                    pack3(21'd0, 21'd0, 21'd17476));
        // All zero: every link collapses to the origin.
        6: begin
          load_box('0, '0, '0, '0, '0, '0);
          item_total = 60;
        end
        // Back to the reset contents by explicit writes, streaming with no idling.
        default: begin
          idling_on <= 1'b0;
          load_box(RST_BOX_A, RST_BOX_B, RST_BOX_C, RST_INV_1, RST_INV_2, RST_INV_3);
        end
      endcase

      @(negedge clk);
      if (phase == 0) begin
        pending_pairs.push_back(pair_of('0, '0, '0, '0, '0, '0));
        // Exact halves in the reduction go toward zero, on both signs.
        pending_pairs.push_back(pair_of('0, '0, '0, 32'h0000_8000, 32'h0001_8000,
                                        32'h7FFF_8000));
        pending_pairs.push_back(pair_of('0, '0, '0, 32'hFFFF_8000, 32'hFFFE_8000,
                                        32'h8000_8000));
        pending_pairs.push_back(pair_of(32'h0000_8000, 32'hFFFF_8000, 32'h8000_0000,
                                        '0, '0, 32'h7FFF_8000));
        // Just inside and just past a half.
        pending_pairs.push_back(pair_of('0, '0, '0, 32'h0000_7FFF, 32'h0000_8001,
                                        32'hFFFF_7FFF));
        pending_pairs.push_back(pair_of('0, '0, '0, 32'hFFFF_8001, 32'h0001_7FFF,
                                        32'h0000_0001));
        // Whole-unit differences reduce to zero.
        pending_pairs.push_back(pair_of('0, '0, '0, 32'h0001_0000, 32'h0002_0000,
                                        32'hFFFF_0000));
        // Widest differences in both directions need all 33 bits.
        pending_pairs.push_back(pair_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        pending_pairs.push_back(pair_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_pairs.push_back(pair_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        '0, '0, '0));
        pending_pairs.push_back(pair_of('0, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        32'hFFFF_FFFF));
        pending_pairs.push_back(pair_of(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                        32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
        pending_pairs.push_back(pair_of(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                        32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
        pending_pairs.push_back(pair_of(32'h7FFF_8000, 32'h8000_0000, 32'h0001_0000,
                                        32'h8000_8000, 32'h7FFF_8000, 32'h0001_0000));
      end
      repeat (item_total) pending_pairs.push_back(random_pair());

      // The phase is over once every pair has been offered and taken and every
      // expected result has come back.
      do begin
        @(negedge clk);
      end while (pending_pairs.size() != 0 || pos_valid || expected_links.size() != 0);
    end

    // Leave room for any stray result transfer before the verdict.
    repeat (4 * PIPE_LATENCY) @(posedge clk);
    if (mismatch_count == 0 && expected_links.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/pml_pkg.sv
hw/rtl/periodic_minimum_image_link.sv
verif/periodic_minimum_image_link_tb.sv
